// ===== design/usm_pkg.sv =====
package usm_pkg;

  localparam int PIX_W        = 8;
  localparam int GAIN_W       = 12;
  localparam int DIM_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // register map of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST   = 12'd256;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd1024;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int GAIN_FRAC_DEF  = 8;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int DIM_MAX        = 2047;

  // quotient of 9 by reciprocal, exact for dividends below 32768
  localparam int              CLIP_LIMIT  = 9 * 256;
  localparam logic [12:0]     RECIP9      = 13'd7282;
  localparam int              RECIP_SHIFT = 16;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  typedef struct packed {
    logic frame_end;
    logic top;
    logic bot;
    logic left;
    logic right;
  } tap_mask_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } out_item_t;

endpackage

// ===== design/usm_ifs.sv =====
interface usm_in_if;
  import usm_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, kind, pixel_in, input ready);
  modport sink (input valid, kind, pixel_in, output ready);
endinterface

interface usm_out_if;
  import usm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;
  modport source (output valid, pixel_out, frame_end, input ready);
  modport sink (input valid, pixel_out, frame_end, output ready);
endinterface

interface usm_cfg_if;
  import usm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/unsharp_mask_sharpen.sv =====
// Unsharp-mask sharpener for an 8-bit grayscale raster stream: one pixel per clock in and
// one per clock out while ready is high and the sink takes results, each output
// p + k*(p - box3x3(p)) rounded and clipped, with zero padding at the frame border.
// Outputs lag their input by one row plus one pixel, and drain items (kind = 1) push out
// the last row once the frame is in. The two previous rows sit in two line memories that
// are read at the accept cycle and written back in the following cycle, with a bypass
// when consecutive items hit the same column (width of one pixel or a counter restart).
// Results go through a five-stage arithmetic pipeline into an 8-entry output queue; ready
// stays high as long as the queue plus the pipeline hold fewer than eight results, so a
// stalled sink costs no throughput until the queue fills. After every write of
// image_width, ready drops while a bit-serial divider re-derives the output row and
// column from the count of emitted pixels; gain and height writes take effect at once.
module unsharp_mask_sharpen #(
  parameter int MAX_WIDTH      = usm_pkg::MAX_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = usm_pkg::GAIN_FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  usm_in_if.sink     in_ch,
  usm_out_if.source  out_ch,
  usm_cfg_if.sink    cfg_ch
);
  import usm_pkg::*;

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int WMAX   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int NCW    = $clog2(WMAX * HEIGHT_LIMIT);
  localparam int DCW    = $clog2(NCW);
  localparam int CRED_W = $clog2(FIFO_DEPTH + 1);
  localparam int TW     = ((GAIN_FRAC_BITS + 12 > 26) ? GAIN_FRAC_BITS + 12 : 26) + 2;
  localparam int UW     = TW - GAIN_FRAC_BITS;
  localparam logic signed [TW-1:0] RND = TW'(9) <<< (GAIN_FRAC_BITS - 1);

  // configuration
  logic [GAIN_W-1:0] gain_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [WW-1:0]     w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic              cfg_fire;
  logic              width_wr;

  // raster position
  logic [CW-1:0]     col_r, col_nxt, col_s;
  logic [DIM_W-1:0]  row_r, row_nxt, row_s;
  logic [NCW-1:0]    n_r, n_nxt, n_s;
  logic [NCW-1:0]    orow_r, orow_nxt, orow_s, orow_inc;
  logic [CW-1:0]     ocol_r, ocol_nxt, ocol_s;
  logic [WW-1:0]     col_inc;
  logic              restart, past_end, proc, emit, ocol_last, frame_end;
  logic              in_fire, in_proc;
  tap_mask_t         mask_s;
  logic [PIX_W-1:0]  val_s;

  // divider
  div_state_t        div_state_r, div_state_nxt;
  logic [NCW-1:0]    div_quo_r, div_quo_nxt, quo_step;
  logic [WW-1:0]     div_rem_r, div_rem_nxt;
  logic [WW:0]       rem_sh, rem_step;
  logic [DCW-1:0]    div_cnt_r, div_cnt_nxt;
  logic              div_done;

  // line memories and window
  logic [PIX_W-1:0]       lsu_mem [MAX_WIDTH];
  logic [PIX_W-1:0]       lsm_mem [MAX_WIDTH];
  logic [PIX_W-1:0]       up_rd_r, mid_rd_r, up_cur, mid_cur;
  logic [8:0][PIX_W-1:0]  win_r;

  // pipeline
  logic                   st1_v_r, st1_emit_r, st1_fwd_r;
  logic [CW-1:0]          st1_col_r;
  logic [PIX_W-1:0]       st1_val_r, st1_fwd_up_r, st1_fwd_mid_r;
  tap_mask_t              st1_mask_r, st2_mask_r;
  logic                   st2_v_r, st3_v_r, st4_v_r, st5_v_r;
  logic                   st3_fe_r, st4_fe_r, st5_fe_r;
  logic [11:0]            tap_sum, p9;
  logic signed [12:0]     st3_diff_r;
  logic [11:0]            st3_p9_r, st4_p9_r;
  logic signed [25:0]     st4_prod_r;
  logic signed [TW-1:0]   t_val;
  logic                   st5_neg_r, st5_big_r;
  logic [11:0]            st5_u_r;
  logic [24:0]            q_prod;
  out_item_t              res_item;

  // output queue
  out_item_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW:0]       wr_ptr_r, rd_ptr_r;
  logic [CRED_W-1:0]      cred_r;
  logic                   out_fire;

  // configuration port
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign width_wr     = cfg_fire && (cfg_ch.index == REG_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        REG_GAIN:   gain_r   <= cfg_ch.data[GAIN_W-1:0];
        REG_WIDTH:  width_r  <= cfg_ch.data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_ch.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_r) > HEIGHT_LIMIT) begin
      h_eff = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_r;
    end
  end

  // input acceptance
  assign in_ch.ready = (cred_r < CRED_W'(FIFO_DEPTH)) && (div_state_r == DIV_IDLE) && !width_wr;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    restart = (WW'(col_r) >= w_eff) || (row_r > h_eff + DIM_W'(1)) ||
              (orow_r >= NCW'(h_eff));
    col_s   = restart ? '0 : col_r;
    row_s   = restart ? '0 : row_r;
    n_s     = restart ? '0 : n_r;
    orow_s  = restart ? '0 : orow_r;
    ocol_s  = restart ? '0 : ocol_r;

    past_end = (row_s >= h_eff);
    proc     = !in_ch.kind || past_end;
    val_s    = past_end ? '0 : in_ch.pixel_in;
    emit     = !((row_s == '0) || ((row_s == DIM_W'(1)) && (col_s == '0)));
    col_inc  = WW'(col_s) + WW'(1);

    ocol_last = (WW'(ocol_s) + WW'(1)) >= w_eff;
    orow_inc  = ocol_last ? orow_s + NCW'(1) : orow_s;
    frame_end = (orow_inc >= NCW'(h_eff));

    mask_s.frame_end = frame_end;
    mask_s.top       = (orow_s == '0);
    mask_s.bot       = (orow_s >= NCW'(h_eff - DIM_W'(1)));
    mask_s.left      = (ocol_s == '0);
    mask_s.right     = ocol_last;
  end

  assign in_proc = in_fire && proc;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    n_nxt    = n_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    if (in_fire) begin
      col_nxt  = col_s;
      row_nxt  = row_s;
      n_nxt    = n_s;
      orow_nxt = orow_s;
      ocol_nxt = ocol_s;
      if (proc) begin
        if (col_inc >= w_eff) begin
          col_nxt = '0;
          row_nxt = row_s + DIM_W'(1);
        end else begin
          col_nxt = CW'(col_inc);
        end
        if (emit) begin
          n_nxt    = n_s + NCW'(1);
          orow_nxt = orow_inc;
          ocol_nxt = ocol_last ? '0 : CW'(WW'(ocol_s) + WW'(1));
          if (frame_end) begin
            col_nxt  = '0;
            row_nxt  = '0;
            n_nxt    = '0;
            orow_nxt = '0;
            ocol_nxt = '0;
          end
        end
      end
    end
    if (div_done) begin
      orow_nxt = div_quo_nxt;
      ocol_nxt = CW'(div_rem_nxt);
    end
  end

  // restoring divider: output position = emitted count divided by the new width
  always_comb begin
    rem_sh   = {div_rem_r, div_quo_r[NCW-1]};
    rem_step = (rem_sh >= {1'b0, w_eff}) ? rem_sh - {1'b0, w_eff} : rem_sh;
    quo_step = {div_quo_r[NCW-2:0], (rem_sh >= {1'b0, w_eff})};
  end

  always_comb begin
    div_state_nxt = div_state_r;
    div_quo_nxt   = div_quo_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    div_done      = 1'b0;
    case (div_state_r)
      DIV_IDLE: begin
        if (width_wr) begin
          div_state_nxt = DIV_RUN;
          div_quo_nxt   = n_r;
          div_rem_nxt   = '0;
          div_cnt_nxt   = '0;
        end
      end
      DIV_RUN: begin
        if (width_wr) begin
          div_quo_nxt = n_r;
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
        end else begin
          div_quo_nxt = quo_step;
          div_rem_nxt = WW'(rem_step);
          div_cnt_nxt = div_cnt_r + DCW'(1);
          if (div_cnt_r == DCW'(NCW - 1)) begin
            div_done      = 1'b1;
            div_state_nxt = DIV_IDLE;
          end
        end
      end
      default: div_state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
    end else begin
      div_state_r <= div_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_quo_r <= div_quo_nxt;
    div_rem_r <= div_rem_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

  // line memories: read at accept, write back in the following cycle
  assign up_cur  = st1_fwd_r ? st1_fwd_up_r  : up_rd_r;
  assign mid_cur = st1_fwd_r ? st1_fwd_mid_r : mid_rd_r;

  always_ff @(posedge clk) begin
    if (in_proc) begin
      up_rd_r  <= lsu_mem[col_s];
      mid_rd_r <= lsm_mem[col_s];
    end
    if (st1_v_r) begin
      lsu_mem[st1_col_r] <= mid_cur;
      lsm_mem[st1_col_r] <= st1_val_r;
    end
  end

  // window taps, row r column k at r*3+k, column 2 newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (st1_v_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= up_cur;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid_cur;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= st1_val_r;
    end
  end

  // zero-padded 3x3 sum and 9*p
  always_comb begin
    tap_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (!((r == 0 && st2_mask_r.top) || (r == 2 && st2_mask_r.bot) ||
              (k == 0 && st2_mask_r.left) || (k == 2 && st2_mask_r.right))) begin
          tap_sum = tap_sum + 12'(win_r[r*3+k]);
        end
      end
    end
    p9 = {win_r[4], 3'b000} + 12'(win_r[4]);
  end

  // round to nearest: floor((num + den/2) / 2^F) then divide by 9
  assign t_val = ($signed(TW'(st4_p9_r)) <<< GAIN_FRAC_BITS) + TW'(st4_prod_r) + RND;

  assign q_prod = 25'(st5_u_r) * 25'(RECIP9);

  always_comb begin
    res_item.frame_end = st5_fe_r;
    if (st5_neg_r) begin
      res_item.pixel = '0;
    end else if (st5_big_r) begin
      res_item.pixel = '1;
    end else begin
      res_item.pixel = q_prod[RECIP_SHIFT +: PIX_W];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      n_r      <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
      st1_v_r  <= 1'b0;
      st2_v_r  <= 1'b0;
      st3_v_r  <= 1'b0;
      st4_v_r  <= 1'b0;
      st5_v_r  <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cred_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      n_r     <= n_nxt;
      orow_r  <= orow_nxt;
      ocol_r  <= ocol_nxt;
      st1_v_r <= in_proc;
      st2_v_r <= st1_v_r && st1_emit_r;
      st3_v_r <= st2_v_r;
      st4_v_r <= st3_v_r;
      st5_v_r <= st4_v_r;
      if (st5_v_r) begin
        wr_ptr_r <= wr_ptr_r + (FIFO_AW+1)'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + (FIFO_AW+1)'(1);
      end
      cred_r <= cred_r + CRED_W'(in_proc && emit) - CRED_W'(out_fire);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_proc) begin
      st1_col_r     <= col_s;
      st1_val_r     <= val_s;
      st1_emit_r    <= emit;
      st1_mask_r    <= mask_s;
      st1_fwd_r     <= st1_v_r && (st1_col_r == col_s);
      st1_fwd_up_r  <= mid_cur;
      st1_fwd_mid_r <= st1_val_r;
    end
    st2_mask_r <= st1_mask_r;
    st3_diff_r <= $signed({1'b0, p9}) - $signed({1'b0, tap_sum});
    st3_p9_r   <= p9;
    st3_fe_r   <= st2_mask_r.frame_end;
    st4_prod_r <= $signed({1'b0, gain_r}) * st3_diff_r;
    st4_p9_r   <= st3_p9_r;
    st4_fe_r   <= st3_fe_r;
    st5_neg_r  <= t_val[TW-1];
    st5_big_r  <= (t_val[TW-1:GAIN_FRAC_BITS] >= UW'(CLIP_LIMIT));
    st5_u_r    <= t_val[GAIN_FRAC_BITS +: 12];
    st5_fe_r   <= st4_fe_r;
    if (st5_v_r) begin
      fifo_r[wr_ptr_r[FIFO_AW-1:0]] <= res_item;
    end
  end

  // output queue
  assign out_ch.valid     = (wr_ptr_r != rd_ptr_r);
  assign out_ch.pixel_out = fifo_r[rd_ptr_r[FIFO_AW-1:0]].pixel;
  assign out_ch.frame_end = fifo_r[rd_ptr_r[FIFO_AW-1:0]].frame_end;
  assign out_fire         = out_ch.valid && out_ch.ready;

  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= CRED_W'(FIFO_DEPTH))
    else $error("result credits exceed queue depth");

  a_queue_within_cred: assert property (@(posedge clk) disable iff (!rst_n)
    CRED_W'(wr_ptr_r - rd_ptr_r) <= cred_r)
    else $error("queue holds more results than credits");

  a_bypass_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_proc) && $past(st1_v_r) && $past(st1_col_r == col_s) |-> st1_fwd_r)
    else $error("same-column back-to-back access not bypassed");

  a_no_accept_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    $past(width_wr) |-> (div_state_r == DIV_RUN) && !in_fire)
    else $error("item accepted while output position is re-derived");

endmodule
